>>> rtl/imhik_pkg.sv
package imhik_pkg;

  localparam int unsigned HeapDepthDefault = 256;
  localparam int unsigned KeyWidthDefault  = 32;
  localparam int unsigned IdWidth          = 8;
  localparam int unsigned IdSpace          = 256;
  localparam int unsigned AmountWidth      = 32;
  localparam int unsigned OutKeyWidth      = 32;
  localparam int unsigned CountWidth       = 9;

  typedef enum logic [1:0] {
    KIND_INSERT   = 2'd0,
    KIND_INCREASE = 2'd1,
    KIND_EXTRACT  = 2'd2,
    KIND_NONE     = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_FULL    = 2'd2,
    ST_UNKNOWN = 2'd3
  } status_t;

endpackage

>>> rtl/indexed_max_heap_increase_key_core.sv
// Channel  | Ports                                             | Direction
// request  | in_valid in_ready in_kind in_entry_id in_amount   | in
// result   | out_valid out_ready out_status out_max_id         | out
//          | out_max_key out_occupancy out_empty_res           |
// One request at a time: in_ready stays low from acceptance until the result has
// been taken, so a stalled out_ready holds the next request off.
// A rejected or no-op request goes straight to the report. An insert or increase
// moves the entry up and an extract moves the last entry down from the root, by
// at most log2 of HEAP_DEPTH levels. Each level costs memory reads, a compare and
// one slot write-back.
// Reset (rst_n, synchronous) clears the presence bits, the count and control.
// The memories are not cleared; only written slots are ever read.
module indexed_max_heap_increase_key_core #(
  parameter int unsigned HEAP_DEPTH = imhik_pkg::HeapDepthDefault,
  parameter int unsigned KEY_WIDTH  = imhik_pkg::KeyWidthDefault
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [1:0]                         in_kind,
  input  logic [imhik_pkg::IdWidth-1:0]      in_entry_id,
  input  logic [imhik_pkg::AmountWidth-1:0]  in_amount,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [1:0]                         out_status,
  output logic [imhik_pkg::IdWidth-1:0]      out_max_id,
  output logic [imhik_pkg::OutKeyWidth-1:0]  out_max_key,
  output logic [imhik_pkg::CountWidth-1:0]   out_occupancy,
  output logic                               out_empty_res
);
  import imhik_pkg::*;

  localparam int unsigned AW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
  localparam int unsigned CW = $clog2(HEAP_DEPTH + 1);
  localparam int unsigned XW = CW + 1;
  localparam logic [KEY_WIDTH-1:0] KeyMax = {KEY_WIDTH{1'b1}};

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_INC_POS, S_INC_KEY, S_EX_ROOT, S_EX_LAST,
    S_UP_CHK, S_UP_CMP, S_PLACE, S_DN_CHK, S_DN_L, S_DN_R, S_DN_MOVE,
    S_RPT_RD, S_RPT
  } state_t;

  // Heap memories: one slot port each, read data registered.
  logic [IdWidth-1:0]   ids_mem [HEAP_DEPTH];
  logic [KEY_WIDTH-1:0] keys_mem [HEAP_DEPTH];
  logic [AW-1:0]        pos_mem [IdSpace];
  logic [IdSpace-1:0]   present_r;

  logic                 h_we, p_we;
  logic [AW-1:0]        h_addr, p_wdata;
  logic [IdWidth-1:0]   h_wid, p_addr;
  logic [KEY_WIDTH-1:0] h_wkey;
  logic [IdWidth-1:0]   h_rid;
  logic [KEY_WIDTH-1:0] h_rkey;
  logic [AW-1:0]        p_rdata;

  always_ff @(posedge clk) begin
    if (h_we) begin
      ids_mem[h_addr]  <= h_wid;
      keys_mem[h_addr] <= h_wkey;
    end
    h_rid  <= ids_mem[h_addr];
    h_rkey <= keys_mem[h_addr];
    if (p_we) begin
      pos_mem[p_addr] <= p_wdata;
    end
    p_rdata <= pos_mem[p_addr];
  end

  state_t                 state_r;
  kind_t                  kind_r;
  logic [IdWidth-1:0]     id_r;
  logic [AmountWidth-1:0] amt_r;
  logic [CW-1:0]          count_r;
  logic [AW-1:0]          cur_r, oth_r;
  logic [IdWidth-1:0]     cid_r, oid_r;
  logic [KEY_WIDTH-1:0]   ckey_r, okey_r;
  status_t                stat_r;
  logic                   rep_r;
  logic                   out_valid_r;
  status_t                out_status_r;
  logic [IdWidth-1:0]     out_max_id_r;
  logic [OutKeyWidth-1:0] out_max_key_r;
  logic [CW-1:0]          out_occ_r;

  logic [XW-1:0] cur_x, lchild, rchild, cnt_x;
  logic [AW-1:0] parent;
  logic [KEY_WIDTH:0] key_sum;
  logic [KEY_WIDTH-1:0] amt_k;

  assign cur_x   = XW'(cur_r);
  assign cnt_x   = XW'(count_r);
  assign lchild  = {cur_x[XW-2:0], 1'b1};
  assign rchild  = lchild + XW'(1);
  assign parent  = AW'((cur_x - XW'(1)) >> 1);
  assign key_sum = {1'b0, h_rkey} + {1'b0, amt_k};

  generate
    if (KEY_WIDTH >= AmountWidth) begin : g_wide
      assign amt_k = KEY_WIDTH'(amt_r);
    end else begin : g_narrow
      assign amt_k = (|amt_r[AmountWidth-1:KEY_WIDTH]) ? KeyMax : amt_r[KEY_WIDTH-1:0];
    end
  endgenerate

  // Memory port steering follows the state. The moving entry is held in
  // cid_r/ckey_r and only written once its final slot is known.
  always_comb begin
    h_we = 1'b0; h_addr = cur_r; h_wid = cid_r; h_wkey = ckey_r;
    p_we = 1'b0; p_addr = cid_r; p_wdata = cur_r;
    unique case (state_r)
      S_DECODE: begin
        h_addr = '0; p_addr = id_r;
      end
      S_INC_POS: h_addr = p_rdata;
      S_EX_ROOT: h_addr = AW'(count_r - CW'(1));
      S_UP_CHK:  h_addr = parent;
      S_UP_CMP: begin
        // A smaller parent moves down into the current slot.
        if (h_rkey < ckey_r) begin
          h_we = 1'b1; h_wid = h_rid; h_wkey = h_rkey;
          p_we = 1'b1; p_addr = h_rid;
        end
      end
      S_PLACE: begin
        h_we = 1'b1; p_we = 1'b1;
      end
      S_DN_CHK: h_addr = AW'(lchild);
      S_DN_L:   h_addr = AW'(rchild);
      S_DN_MOVE: begin
        // The larger child moves up into the current slot.
        if (oth_r != cur_r) begin
          h_we = 1'b1; h_wid = oid_r; h_wkey = okey_r;
          p_we = 1'b1; p_addr = oid_r;
        end
      end
      S_RPT_RD: h_addr = '0;
      default: ;
    endcase
  end

  assign in_ready = (state_r == S_IDLE) && !out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      present_r   <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == S_RPT) out_valid_r <= 1'b1;
      else if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: if (in_valid && in_ready) begin
          kind_r <= kind_t'(in_kind); id_r <= in_entry_id; amt_r <= in_amount;
          stat_r <= ST_OK; rep_r <= 1'b0;
          state_r <= S_DECODE;
        end
        S_DECODE: begin
          unique case (kind_r)
            KIND_INSERT: begin
              if (present_r[id_r] || count_r >= CW'(HEAP_DEPTH)) begin
                stat_r <= ST_FULL; state_r <= S_RPT_RD;
              end else begin
                // The new entry starts at the first free slot.
                cur_r <= AW'(count_r); cid_r <= id_r; ckey_r <= amt_k;
                present_r[id_r] <= 1'b1;
                count_r <= count_r + CW'(1);
                state_r <= S_UP_CHK;
              end
            end
            KIND_INCREASE: begin
              if (!present_r[id_r]) begin
                stat_r <= ST_UNKNOWN; state_r <= S_RPT_RD;
              end else state_r <= S_INC_POS;
            end
            KIND_EXTRACT: begin
              if (count_r == '0) begin
                stat_r <= ST_EMPTY; state_r <= S_RPT_RD;
              end else state_r <= S_EX_ROOT;
            end
            KIND_NONE: state_r <= S_RPT_RD;
          endcase
        end
        S_INC_POS: begin
          cur_r <= p_rdata; cid_r <= id_r;
          state_r <= S_INC_KEY;
        end
        S_INC_KEY: begin
          ckey_r <= key_sum[KEY_WIDTH] ? KeyMax : key_sum[KEY_WIDTH-1:0];
          state_r <= S_UP_CHK;
        end
        S_EX_ROOT: begin
          out_max_id_r  <= h_rid;
          out_max_key_r <= OutKeyWidth'(h_rkey);
          rep_r <= 1'b1;
          present_r[h_rid] <= 1'b0;
          count_r <= count_r - CW'(1);
          state_r <= S_EX_LAST;
        end
        S_EX_LAST: begin
          cid_r <= h_rid; ckey_r <= h_rkey; cur_r <= '0;
          state_r <= (count_r == '0) ? S_RPT_RD : S_DN_CHK;
        end
        S_UP_CHK: state_r <= (cur_r == '0) ? S_PLACE : S_UP_CMP;
        S_UP_CMP: begin
          if (h_rkey < ckey_r) begin
            cur_r <= parent;
            state_r <= S_UP_CHK;
          end else state_r <= S_PLACE;
        end
        S_PLACE: state_r <= S_RPT_RD;
        S_DN_CHK: state_r <= (lchild >= cnt_x) ? S_PLACE : S_DN_L;
        S_DN_L: begin
          if (h_rkey > ckey_r) begin
            oth_r <= AW'(lchild); oid_r <= h_rid; okey_r <= h_rkey;
          end else begin
            oth_r <= cur_r; oid_r <= cid_r; okey_r <= ckey_r;
          end
          state_r <= (rchild < cnt_x) ? S_DN_R : S_DN_MOVE;
        end
        S_DN_R: begin
          // The left child keeps a tie with the right one.
          if (h_rkey > okey_r) begin
            oth_r <= AW'(rchild); oid_r <= h_rid; okey_r <= h_rkey;
          end
          state_r <= S_DN_MOVE;
        end
        S_DN_MOVE: begin
          if (oth_r == cur_r) state_r <= S_PLACE;
          else begin
            cur_r <= oth_r;
            state_r <= S_DN_CHK;
          end
        end
        S_RPT_RD: state_r <= S_RPT;
        S_RPT: begin
          out_status_r <= stat_r;
          out_occ_r    <= count_r;
          if (!rep_r) begin
            out_max_id_r  <= (count_r == '0) ? '0 : h_rid;
            out_max_key_r <= (count_r == '0) ? '0 : OutKeyWidth'(h_rkey);
          end
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_max_id    = out_max_id_r;
  assign out_max_key   = out_max_key_r;
  assign out_occupancy = CountWidth'(out_occ_r);
  assign out_empty_res = (out_occ_r == '0);

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(HEAP_DEPTH)) else $error("count beyond depth");
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> state_r == S_IDLE) else $error("ready while busy");
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready) else $error("second request taken");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid && $stable(out_status) &&
    $stable(out_max_id) && $stable(out_max_key) && $stable(out_occupancy))
    else $error("result changed while waiting");

endmodule

>>> verif/tb_indexed_max_heap_increase_key_core.sv
`timescale 1ns / 1ps

module tb_indexed_max_heap_increase_key_core;
  import imhik_pkg::*;

  localparam int unsigned Depth = HeapDepthDefault;
  localparam logic [31:0] KeyMax = 32'hFFFF_FFFF;
  localparam int unsigned CycleLimit = 2000000;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  entry_id;
    logic [31:0] amount;
  } heap_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  max_id;
    logic [31:0] max_key;
    logic [8:0]  occupancy;
    logic        empty_res;
  } heap_res_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_kind = '0;
  logic [7:0]  in_entry_id = '0;
  logic [31:0] in_amount = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_status;
  logic [7:0]  out_max_id;
  logic [31:0] out_max_key;
  logic [8:0]  out_occupancy;
  logic        out_empty_res;

  heap_req_t pending_reqs[$];
  heap_res_t expected_results[$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned errors = 0;
  int unsigned cycle_count = 0;
  bit          hold_off = 1'b0;

  // Predictor state: the heap as seen by the testbench.
  logic [7:0]  p_ids[Depth];
  logic [31:0] p_keys[Depth];
  int unsigned p_pos[IdSpace];
  bit          p_present[IdSpace];
  int unsigned p_count = 0;

  // Estimate of the occupancy for building meaningful requests.
  int unsigned live_count;

  always #5 clk = ~clk;

  indexed_max_heap_increase_key_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_kind(in_kind),
    .in_entry_id(in_entry_id), .in_amount(in_amount),
    .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
    .out_max_id(out_max_id), .out_max_key(out_max_key),
    .out_occupancy(out_occupancy), .out_empty_res(out_empty_res)
  );

  function automatic void swap_slots(int unsigned a, int unsigned b);
    logic [7:0]  tid;
    logic [31:0] tkey;
    tid = p_ids[a];
    tkey = p_keys[a];
    p_ids[a] = p_ids[b];
    p_keys[a] = p_keys[b];
    p_ids[b] = tid;
    p_keys[b] = tkey;
    p_pos[p_ids[a]] = a;
    p_pos[p_ids[b]] = b;
  endfunction

  function automatic void bubble_up(int unsigned p);
    int unsigned par;
    while (p > 0 && p < p_count) begin
      par = (p - 1) / 2;
      if (p_keys[par] < p_keys[p]) begin
        swap_slots(par, p);
        p = par;
      end else begin
        break;
      end
    end
  endfunction

  function automatic void bubble_down(int unsigned p);
    int unsigned l, r, big;
    while (p < p_count) begin
      l = 2 * p + 1;
      r = 2 * p + 2;
      big = p;
      if (l < p_count && p_keys[l] > p_keys[big]) big = l;
      if (r < p_count && p_keys[r] > p_keys[big]) big = r;
      if (big == p) break;
      swap_slots(p, big);
      p = big;
    end
  endfunction

  function automatic heap_res_t apply_heap_op(heap_req_t rq);
    heap_res_t   res;
    bit          reported;
    int unsigned p;
    logic [32:0] sum;
    res = '0;
    reported = 1'b0;
    case (kind_t'(rq.kind))
      KIND_INSERT: begin
        if (p_present[rq.entry_id] || p_count >= Depth) begin
          res.status = ST_FULL;
        end else begin
          p = p_count;
          p_ids[p] = rq.entry_id;
          p_keys[p] = rq.amount;
          p_pos[rq.entry_id] = p;
          p_present[rq.entry_id] = 1'b1;
          p_count = p + 1;
          bubble_up(p);
        end
      end
      KIND_INCREASE: begin
        if (!p_present[rq.entry_id]) begin
          res.status = ST_UNKNOWN;
        end else begin
          p = p_pos[rq.entry_id];
          sum = {1'b0, p_keys[p]} + {1'b0, rq.amount};
          p_keys[p] = sum[32] ? KeyMax : sum[31:0];
          bubble_up(p);
        end
      end
      KIND_EXTRACT: begin
        if (p_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.max_id = p_ids[0];
          res.max_key = p_keys[0];
          reported = 1'b1;
          p_present[p_ids[0]] = 1'b0;
          p_count--;
          p_ids[0] = p_ids[p_count];
          p_keys[0] = p_keys[p_count];
          if (p_count > 0) begin
            p_pos[p_ids[0]] = 0;
            bubble_down(0);
          end
        end
      end
      default: ;
    endcase
    if (!reported && p_count > 0) begin
      res.max_id = p_ids[0];
      res.max_key = p_keys[0];
    end
    res.occupancy = p_count[8:0];
    res.empty_res = (p_count == 0);
    return res;
  endfunction

  logic in_fire = 1'b0;

  always @(posedge clk) begin
    in_fire <= rst_n && in_valid && in_ready;
  end

  // Driver: presents queued requests, changing inputs on the falling edge.
  always @(negedge clk) begin
    heap_req_t rq;
    logic      next_valid;
    next_valid = in_valid && !in_fire;
    if (rst_n && !next_valid && !hold_off && pending_reqs.size() > 0 &&
        $urandom_range(99) >= send_idle_pct) begin
      rq = pending_reqs.pop_front();
      in_kind <= rq.kind;
      in_entry_id <= rq.entry_id;
      in_amount <= rq.amount;
      expected_results = {expected_results, apply_heap_op(rq)};
      next_valid = 1'b1;
    end
    in_valid <= next_valid;
    out_ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
  end

  // Monitor: checks each result against the oldest expectation.
  always @(posedge clk) begin
    heap_res_t exp_res;
    cycle_count <= cycle_count + 1;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("result with no request outstanding");
        errors = errors + 1;
      end else begin
        exp_res = expected_results.pop_front();
        if (out_status !== exp_res.status) begin
          $error("status: expected %0d actual %0d", exp_res.status, out_status);
          errors = errors + 1;
        end
        if (out_max_id !== exp_res.max_id) begin
          $error("max_id: expected %0d actual %0d", exp_res.max_id, out_max_id);
          errors = errors + 1;
        end
        if (out_max_key !== exp_res.max_key) begin
          $error("max_key: expected %0h actual %0h", exp_res.max_key, out_max_key);
          errors = errors + 1;
        end
        if (out_occupancy !== exp_res.occupancy) begin
          $error("occupancy: expected %0d actual %0d", exp_res.occupancy,
                 out_occupancy);
          errors = errors + 1;
        end
        if (out_empty_res !== exp_res.empty_res) begin
          $error("empty_res: expected %0d actual %0d", exp_res.empty_res,
                 out_empty_res);
          errors = errors + 1;
        end
      end
    end
    if (cycle_count >= CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic queue_req(input kind_t k, input int unsigned id,
                           input logic [31:0] amt);
    heap_req_t rq;
    rq.kind = k;
    rq.entry_id = id[7:0];
    rq.amount = amt;
    pending_reqs = {pending_reqs, rq};
  endtask

  task automatic drain_all();
    while (pending_reqs.size() > 0 || expected_results.size() > 0 || in_valid)
      @(posedge clk);
  endtask

  // Random mix biased by a target fill level so the heap both fills and drains.
  task automatic queue_random(input int unsigned n, input int unsigned target);
    int unsigned r, id;
    logic [31:0] amt;
    for (int unsigned i = 0; i < n; i++) begin
      r = $urandom_range(99);
      id = $urandom_range(255);
      case ($urandom_range(3))
        0: amt = $urandom;
        1: amt = $urandom_range(15);
        2: amt = KeyMax - $urandom_range(3);
        default: amt = $urandom_range(1000);
      endcase
      if (r < 2) begin
        queue_req(KIND_NONE, id, amt);
      end else if (r < 40) begin
        if (live_count < target) begin
          queue_req(KIND_INSERT, id, amt);
          live_count++;
        end else begin
          queue_req(KIND_EXTRACT, id, amt);
          if (live_count > 0) live_count--;
        end
      end else if (r < 70) begin
        queue_req(KIND_INCREASE, id, amt);
      end else if (r < 85) begin
        queue_req(KIND_INSERT, id, amt);
        if (live_count < Depth) live_count++;
      end else begin
        queue_req(KIND_EXTRACT, id, amt);
        if (live_count > 0) live_count--;
      end
    end
  endtask

  initial begin
    live_count = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed requests: empty cases, extremes, duplicates, ties, saturation.
    queue_req(KIND_EXTRACT, 0, 32'd0);
    queue_req(KIND_INCREASE, 8'hFF, 32'd5);
    queue_req(KIND_NONE, 8'hAA, 32'h5555_5555);
    queue_req(KIND_INSERT, 0, 32'd0);
    queue_req(KIND_INSERT, 255, KeyMax);
    queue_req(KIND_INSERT, 255, 32'd1);
    queue_req(KIND_INSERT, 8'h55, 32'hAAAA_AAAA);
    queue_req(KIND_INSERT, 8'hAA, 32'hAAAA_AAAA);
    queue_req(KIND_INCREASE, 0, KeyMax);
    queue_req(KIND_INCREASE, 8'h55, 32'h6000_0000);
    queue_req(KIND_INCREASE, 8'h12, 32'd1);
    queue_req(KIND_NONE, 0, 32'd0);
    repeat (6) queue_req(KIND_EXTRACT, 0, 32'd0);
    queue_req(KIND_INSERT, 7, 32'd3);
    queue_req(KIND_INSERT, 8, 32'd3);
    queue_req(KIND_INSERT, 9, 32'd3);
    queue_req(KIND_EXTRACT, 0, 32'd0);
    queue_req(KIND_EXTRACT, 0, 32'd0);
    queue_req(KIND_EXTRACT, 0, 32'd0);
    drain_all();

    // Fill to capacity, then attempt one more insert, then empty out.
    for (int unsigned i = 0; i < Depth; i++)
      queue_req(KIND_INSERT, i, $urandom_range(63));
    queue_req(KIND_INSERT, 3, 32'd1);
    for (int unsigned i = 0; i < Depth; i++)
      queue_req(KIND_EXTRACT, 0, 32'd0);
    live_count = 0;

    queue_random(350, 40);
    drain_all();
    // The sender holds off here until every result has come back.
    hold_off = 1'b1;
    drain_all();
    hold_off = 1'b0;

    send_idle_pct = 59;
    queue_random(250, 12);
    drain_all();
    send_idle_pct = 0;
    recv_stall_pct = 59;
    queue_random(250, 200);
    drain_all();
    send_idle_pct = 37;
    recv_stall_pct = 37;
    queue_random(250, 20);
    drain_all();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    queue_random(100, 8);
    drain_all();

    repeat (50) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/imhik_pkg.sv
rtl/indexed_max_heap_increase_key_core.sv
verif/tb_indexed_max_heap_increase_key_core.sv
